/* src/vsfc_pkg.sv */
// Package for the voxel surface face classifier.
// Widths, grid limits, codes, controller states and the command/status structs.
// No dependencies.
package vsfc_pkg;

	localparam int COORD_W = 6;
	localparam int SIZE_W  = 7;
	localparam int ADDR_W  = 3 * COORD_W;
	localparam int CNT_W   = 5;
	localparam int OFS_W   = 2;
	localparam int CFG_W   = 2;

	localparam logic [SIZE_W-1:0] MAX_X      = 7'd64;
	localparam logic [SIZE_W-1:0] MAX_Y      = 7'd64;
	localparam logic [SIZE_W-1:0] MAX_Z      = 7'd64;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

	// neighbourhood sweep: 3x3x3 reads, offsets 0..2 map to -1..+1
	localparam logic [CNT_W-1:0] NBR_TOTAL = 5'd27;
	localparam logic [OFS_W-1:0] OFS_LAST  = 2'd2;
	localparam logic [OFS_W-1:0] OFS_MID   = 2'd1;

	localparam logic MODE_WRITE    = 1'b0;
	localparam logic MODE_CLASSIFY = 1'b1;

	typedef enum logic [CFG_W-1:0] {
		CFG_SIZE_X = 2'd0,
		CFG_SIZE_Y = 2'd1,
		CFG_SIZE_Z = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		CLS_EMPTY      = 2'd0,
		CLS_SOLID      = 2'd1,
		CLS_VERTICAL   = 2'd2,
		CLS_HORIZONTAL = 2'd3
	} vox_class_t;

	typedef enum logic [2:0] {
		RES_ERROR,
		RES_WRITE,
		RES_EMPTY,
		RES_SOLID,
		RES_HORIZ,
		RES_SWEEP
	} res_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_CENTRE,
		ST_SWEEP,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic     in_ready;
		logic     load;
		logic     mem_wr;
		logic     sweep_clr;
		logic     sweep_step;
		logic     res_load;
		res_sel_t res_sel;
		logic     out_load;
	} vsfc_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic coord_err;
		logic is_write;
		logic centre_occ;
		logic border;
		logic ground;
		logic sweep_done;
		logic out_free;
	} vsfc_sts_t;

endpackage

/* src/vsfc_if.sv */
// Channel interfaces: request items, result items and the configuration write channel.
// Depends on vsfc_pkg.
interface vsfc_req_if import vsfc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               mode;
	logic [COORD_W-1:0] coord_x;
	logic [COORD_W-1:0] coord_y;
	logic [COORD_W-1:0] coord_z;
	logic               occupied;

	modport source (output valid, mode, coord_x, coord_y, coord_z, occupied, input ready);
	modport sink   (input valid, mode, coord_x, coord_y, coord_z, occupied, output ready);
endinterface

interface vsfc_rsp_if import vsfc_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] voxel_class;
	logic       error;

	modport source (output valid, voxel_class, error, input ready);
	modport sink   (input valid, voxel_class, error, output ready);
endinterface

interface vsfc_cfg_if import vsfc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CFG_W-1:0]  index;
	logic [SIZE_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* src/vsfc_ram.sv */
// Generic single-port RAM, one access per cycle, registered read data.
// No dependencies.
module vsfc_ram #(
	parameter int AW = 18,
	parameter int DW = 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

/* src/vsfc_ctrl.sv */
// Controller state machine: sequences check, store access, neighbourhood sweep and result.
// Depends on vsfc_pkg.
module vsfc_ctrl import vsfc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  vsfc_sts_t sts,
	output vsfc_cmd_t cmd
);

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sts.in_valid) state_nx = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.coord_err || sts.is_write) state_nx = ST_FINISH;
				else state_nx = ST_CENTRE;
			end
			ST_CENTRE: begin
				if (!sts.centre_occ || sts.border || sts.ground) state_nx = ST_FINISH;
				else state_nx = ST_SWEEP;
			end
			ST_SWEEP: begin
				if (sts.sweep_done) state_nx = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.res_sel = RES_ERROR;
		case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				cmd.load     = sts.in_valid;
			end
			ST_CHECK: begin
				// a classify reads the centre voxel at the latched address
				if (sts.coord_err) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_ERROR;
				end else if (sts.is_write) begin
					cmd.mem_wr   = 1'b1;
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_WRITE;
				end
			end
			ST_CENTRE: begin
				// centre bit arrives from the store this cycle
				if (!sts.centre_occ) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_EMPTY;
				end else if (sts.border) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_SOLID;
				end else if (sts.ground) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_HORIZ;
				end else begin
					cmd.sweep_clr = 1'b1;
				end
			end
			ST_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (sts.sweep_done) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_SWEEP;
				end
			end
			ST_FINISH: begin
				cmd.out_load = sts.out_free;
			end
			default: ;
		endcase
	end

endmodule

/* src/vsfc_dp.sv */
// Datapath: size registers, item latch, store addressing, sweep accumulator, result register.
// Depends on vsfc_pkg and the channel interfaces.
module vsfc_dp import vsfc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	vsfc_req_if.sink          req,
	vsfc_cfg_if.sink          cfg,
	vsfc_rsp_if.source        rsp,
	input  vsfc_cmd_t         cmd,
	output vsfc_sts_t         sts,
	output logic              mem_we,
	output logic [ADDR_W-1:0] mem_addr,
	output logic              mem_wdata,
	input  logic              mem_rdata
);

	logic [SIZE_W-1:0]  size_x_q, size_y_q, size_z_q;
	logic [SIZE_W-1:0]  sx, sy, sz;
	logic               mode_q, occ_q;
	logic [COORD_W-1:0] x_q, y_q, z_q;
	logic [SIZE_W-1:0]  xe, ye, ze;

	logic [CNT_W-1:0]   cnt_q;
	logic [OFS_W-1:0]   ix_q, iy_q, iz_q;
	logic [OFS_W-1:0]   px_q, py_q, pz_q;
	logic               pvalid_q, all_q, side_q;
	logic               all_nx, side_nx, prev_side, issue;
	logic [COORD_W-1:0] nx, ny, nz;

	logic [1:0]         res_cls_q;
	logic               res_err_q;
	logic               rsp_valid_q;
	logic [1:0]         rsp_cls_q;
	logic               rsp_err_q;
	vox_class_t         sweep_cls;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SIZE_RESET;
			size_y_q <= SIZE_RESET;
			size_z_q <= SIZE_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_SIZE_X: size_x_q <= cfg.data;
				CFG_SIZE_Y: size_y_q <= cfg.data;
				CFG_SIZE_Z: size_z_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign sx = (size_x_q > MAX_X) ? MAX_X : size_x_q;
	assign sy = (size_y_q > MAX_Y) ? MAX_Y : size_y_q;
	assign sz = (size_z_q > MAX_Z) ? MAX_Z : size_z_q;

	// item latch
	assign req.ready = cmd.in_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= req.mode;
			x_q    <= req.coord_x;
			y_q    <= req.coord_y;
			z_q    <= req.coord_z;
			occ_q  <= req.occupied;
		end
	end

	assign xe = {1'b0, x_q};
	assign ye = {1'b0, y_q};
	assign ze = {1'b0, z_q};

	assign sts.in_valid   = req.valid;
	assign sts.coord_err  = (xe >= sx) || (ye >= sy) || (ze >= sz);
	assign sts.is_write   = (mode_q == MODE_WRITE);
	assign sts.centre_occ = mem_rdata;
	assign sts.border     = (x_q == '0) || (y_q == '0) ||
	                        (xe + 7'd1 >= sx) || (ye + 7'd1 >= sy) || (ze + 7'd1 >= sz);
	assign sts.ground     = (z_q == '0);
	assign sts.sweep_done = (cnt_q == NBR_TOTAL);
	assign sts.out_free   = !rsp_valid_q || rsp.ready;

	// store access; neighbour offsets run 0..2 for -1..+1
	assign issue = cmd.sweep_step && (cnt_q != NBR_TOTAL);
	assign nx    = x_q + {{(COORD_W-OFS_W){1'b0}}, ix_q} - 6'd1;
	assign ny    = y_q + {{(COORD_W-OFS_W){1'b0}}, iy_q} - 6'd1;
	assign nz    = z_q + {{(COORD_W-OFS_W){1'b0}}, iz_q} - 6'd1;

	assign mem_we    = cmd.mem_wr;
	assign mem_wdata = occ_q;
	assign mem_addr  = cmd.sweep_step ? {nx, ny, nz} : {x_q, y_q, z_q};

	// the four in-plane side neighbours: same layer, exactly one of x or y offset
	assign prev_side = (pz_q == OFS_MID) &&
	                   ((px_q == OFS_MID) != (py_q == OFS_MID));
	assign all_nx    = all_q & (!pvalid_q | mem_rdata);
	assign side_nx   = side_q | (pvalid_q & prev_side & !mem_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			ix_q     <= '0;
			iy_q     <= '0;
			iz_q     <= '0;
			pvalid_q <= 1'b0;
			all_q    <= 1'b1;
			side_q   <= 1'b0;
		end else if (cmd.sweep_clr) begin
			cnt_q    <= '0;
			ix_q     <= '0;
			iy_q     <= '0;
			iz_q     <= '0;
			pvalid_q <= 1'b0;
			all_q    <= 1'b1;
			side_q   <= 1'b0;
		end else if (cmd.sweep_step) begin
			all_q    <= all_nx;
			side_q   <= side_nx;
			pvalid_q <= issue;
			if (issue) begin
				cnt_q <= cnt_q + 5'd1;
				if (iz_q == OFS_LAST) begin
					iz_q <= '0;
					if (iy_q == OFS_LAST) begin
						iy_q <= '0;
						ix_q <= ix_q + 2'd1;
					end else begin
						iy_q <= iy_q + 2'd1;
					end
				end else begin
					iz_q <= iz_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			px_q <= ix_q;
			py_q <= iy_q;
			pz_q <= iz_q;
		end
	end

	assign sweep_cls = all_nx ? CLS_SOLID : (side_nx ? CLS_VERTICAL : CLS_HORIZONTAL);

	// result staging and output register
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_err_q <= (cmd.res_sel == RES_ERROR);
			case (cmd.res_sel)
				RES_ERROR: res_cls_q <= CLS_EMPTY;
				RES_WRITE: res_cls_q <= CLS_EMPTY;
				RES_EMPTY: res_cls_q <= CLS_EMPTY;
				RES_SOLID: res_cls_q <= CLS_SOLID;
				RES_HORIZ: res_cls_q <= CLS_HORIZONTAL;
				RES_SWEEP: res_cls_q <= sweep_cls;
				default:   res_cls_q <= CLS_EMPTY;
			endcase
		end
		if (cmd.out_load) begin
			rsp_cls_q <= res_cls_q;
			rsp_err_q <= res_err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.voxel_class = rsp_cls_q;
	assign rsp.error       = rsp_err_q;

endmodule

/* src/voxel_surface_face_classifier.sv */
// A write or out-of-range item ends at the check; a classify may end at the centre voxel;
// a full classify makes 27 neighbourhood reads through the single store port, one per
// cycle, and loads its result register once the last read has returned from the store.
// Throughput: one item at a time; a new item is taken while the last result waits.
// Reset: arst_n clears control state and sets sizes to 64; the voxel store is not cleared.
// Depends on vsfc_pkg, the channel interfaces, vsfc_ram, vsfc_ctrl and vsfc_dp.
module voxel_surface_face_classifier import vsfc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	vsfc_req_if.sink   req,
	vsfc_cfg_if.sink   cfg,
	vsfc_rsp_if.source rsp
);

	vsfc_cmd_t         cmd;
	vsfc_sts_t         sts;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_addr;
	logic              mem_wdata;
	logic              mem_rdata;

	vsfc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	vsfc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg       (cfg),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts),
		.mem_we    (mem_we),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata)
	);

	vsfc_ram #(
		.AW (ADDR_W),
		.DW (1)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

endmodule

/* tb/voxel_surface_face_classifier_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for voxel_surface_face_classifier: directed and random voxel items
// against an in-bench predictor of the occupancy grid and surface classes.
// Depends on vsfc_pkg, the vsfc channel interfaces and the RTL of the block.
module voxel_surface_face_classifier_test;
	import vsfc_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int END_SETTLE  = 48;
	localparam int GRID_CELLS  = int'(MAX_X) * int'(MAX_Y) * int'(MAX_Z);
	localparam int BOX_MAX     = 5;

	typedef struct packed {
		logic               mode;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic               occupied;
	} vox_req_t;

	typedef struct packed {
		vox_class_t cls;
		logic       err;
	} vox_face_t;

	typedef enum int {RX_ALWAYS, RX_PATTERN, RX_RANDOM} rx_style_t;

	logic clk;
	logic arst_n;

	vsfc_req_if req_ch ();
	vsfc_cfg_if cfg_ch ();
	vsfc_rsp_if rsp_ch ();

	voxel_surface_face_classifier u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.cfg    (cfg_ch),
		.rsp    (rsp_ch)
	);

	// mirror of the voxel store and of the size registers
	bit                occ_grid [GRID_CELLS];
	bit                wr_seen  [GRID_CELLS];
	logic [SIZE_W-1:0] grid_size [3];

	vox_face_t face_q [$];

	int        fail_count;
	int        n_items;
	int        n_results;
	int        n_settings;
	int        n_class [4];
	int        n_err;
	int        burst_left;
	bit        tx_idle;
	rx_style_t rx_style;
	int        hold_req;
	int        box_x0, box_y0, box_z0, box_nx, box_ny, box_nz;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int eff_size(logic [SIZE_W-1:0] v, logic [SIZE_W-1:0] lim);
		return (v > lim) ? int'(lim) : int'(v);
	endfunction

	function automatic int vox_addr(int x, int y, int z);
		return (x * int'(MAX_Y) + y) * int'(MAX_Z) + z;
	endfunction

	function automatic vox_req_t vox(logic m, int x, int y, int z, logic occ);
		vox_req_t r;
		r.mode     = m;
		r.x        = x[COORD_W-1:0];
		r.y        = y[COORD_W-1:0];
		r.z        = z[COORD_W-1:0];
		r.occupied = occ;
		return r;
	endfunction

	// true unless a classify would touch a voxel that was never written
	function automatic bit read_is_defined(vox_req_t r);
		int sx, sy, sz, x, y, z;
		sx = eff_size(grid_size[CFG_SIZE_X], MAX_X);
		sy = eff_size(grid_size[CFG_SIZE_Y], MAX_Y);
		sz = eff_size(grid_size[CFG_SIZE_Z], MAX_Z);
		x = int'(r.x);
		y = int'(r.y);
		z = int'(r.z);
		if (r.mode == MODE_WRITE || x >= sx || y >= sy || z >= sz)
			return 1'b1;
		if (!wr_seen[vox_addr(x, y, z)])
			return 1'b0;
		if (!occ_grid[vox_addr(x, y, z)] || x == 0 || y == 0 || x + 1 >= sx || y + 1 >= sy
				|| z + 1 >= sz || z == 0)
			return 1'b1;
		for (int dx = -1; dx <= 1; dx++)
			for (int dy = -1; dy <= 1; dy++)
				for (int dz = -1; dz <= 1; dz++)
					if (!wr_seen[vox_addr(x + dx, y + dy, z + dz)])
						return 1'b0;
		return 1'b1;
	endfunction

	// expected result of one accepted item; a write updates the mirror
	function automatic vox_face_t predict_face(vox_req_t r);
		vox_face_t f;
		int        sx, sy, sz, x, y, z, n_occ;
		bit        side_gap;
		sx = eff_size(grid_size[CFG_SIZE_X], MAX_X);
		sy = eff_size(grid_size[CFG_SIZE_Y], MAX_Y);
		sz = eff_size(grid_size[CFG_SIZE_Z], MAX_Z);
		x = int'(r.x);
		y = int'(r.y);
		z = int'(r.z);
		f.cls = CLS_EMPTY;
		f.err = 1'b0;
		if (x >= sx || y >= sy || z >= sz) begin
			f.err = 1'b1;
			return f;
		end
		if (r.mode == MODE_WRITE) begin
			occ_grid[vox_addr(x, y, z)] = r.occupied;
			wr_seen[vox_addr(x, y, z)]  = 1'b1;
			return f;
		end
		if (!occ_grid[vox_addr(x, y, z)]) begin
			f.cls = CLS_EMPTY;
		end else if (x == 0 || y == 0 || x + 1 >= sx || y + 1 >= sy || z + 1 >= sz) begin
			f.cls = CLS_SOLID;
		end else if (z == 0) begin
			f.cls = CLS_HORIZONTAL;
		end else begin
			n_occ = 0;
			for (int dx = -1; dx <= 1; dx++)
				for (int dy = -1; dy <= 1; dy++)
					for (int dz = -1; dz <= 1; dz++)
						n_occ += int'(occ_grid[vox_addr(x + dx, y + dy, z + dz)]);
			side_gap = !occ_grid[vox_addr(x - 1, y, z)] || !occ_grid[vox_addr(x + 1, y, z)]
				|| !occ_grid[vox_addr(x, y - 1, z)] || !occ_grid[vox_addr(x, y + 1, z)];
			if (n_occ == int'(NBR_TOTAL))
				f.cls = CLS_SOLID;
			else if (side_gap)
				f.cls = CLS_VERTICAL;
			else
				f.cls = CLS_HORIZONTAL;
		end
		return f;
	endfunction

	function automatic void queue_face(vox_face_t f);
		face_q.insert(face_q.size(), f);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s, got %0d, expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	task automatic check_face();
		vox_face_t want;
		if (face_q.size() == 0) begin
			report_mismatch("result item with nothing pending", int'(rsp_ch.voxel_class), -1);
			return;
		end
		want = face_q.pop_front();
		n_results++;
		n_class[want.cls]++;
		if (want.err)
			n_err++;
		if (rsp_ch.voxel_class !== want.cls)
			report_mismatch("voxel_class", int'(rsp_ch.voxel_class), int'(want.cls));
		if (rsp_ch.error !== want.err)
			report_mismatch("error", int'(rsp_ch.error), int'(want.err));
	endtask

	// result side: checks each accepted item and drives ready
	initial begin
		int hold_left;
		int rx_tick;
		hold_left = 0;
		rx_tick   = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready)
				check_face();
			rx_tick++;
			if (hold_left == 0 && hold_req != 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				case (rx_style)
					RX_ALWAYS:  rsp_ch.ready <= 1'b1;
					RX_PATTERN: rsp_ch.ready <= (rx_tick % 13) >= 4;
					default:    rsp_ch.ready <= $urandom_range(0, 2) != 0;
				endcase
			end
		end
	end

	// ends the run when nothing has moved for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
		$display("FAIL");
		$finish;
	end

	task automatic send_voxel(input vox_req_t r);
		int gap;
		if (tx_idle && burst_left == 0) begin
			gap = $urandom_range(1, 8);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 16);
		end
		req_ch.valid    <= 1'b1;
		req_ch.mode     <= r.mode;
		req_ch.coord_x  <= r.x;
		req_ch.coord_y  <= r.y;
		req_ch.coord_z  <= r.z;
		req_ch.occupied <= r.occupied;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		queue_face(predict_face(r));
		if (burst_left > 0)
			burst_left--;
		n_items++;
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (face_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_grid(input logic [SIZE_W-1:0] nx, ny, nz);
		cfg_idx_t          regs [3];
		logic [SIZE_W-1:0] vals [3];
		regs = '{CFG_SIZE_X, CFG_SIZE_Y, CFG_SIZE_Z};
		vals = '{nx, ny, nz};
		drain_results();
		for (int i = 0; i < 3; i++) begin
			cfg_ch.index <= regs[i];
			cfg_ch.data  <= vals[i];
			cfg_ch.valid <= 1'b1;
			@(posedge clk);
			while (!cfg_ch.ready)
				@(posedge clk);
			grid_size[regs[i]] = vals[i];
		end
		cfg_ch.valid <= 1'b0;
		n_settings++;
	endtask

	function automatic vox_req_t random_voxel(int occ_pct);
		vox_req_t r;
		int       sel;
		r.occupied = $urandom_range(0, 99) < occ_pct;
		sel = $urandom_range(0, 99);
		if (sel < 10) begin
			// raw coordinates, mostly out of range on small grids
			r.mode = 1'($urandom_range(0, 1));
			r.x    = COORD_W'($urandom);
			r.y    = COORD_W'($urandom);
			r.z    = COORD_W'($urandom);
		end else if (sel < 22) begin
			r.mode = 1'($urandom_range(0, 1));
			r.x    = COORD_W'($urandom_range(0, eff_size(grid_size[CFG_SIZE_X], MAX_X) - 1));
			r.y    = COORD_W'($urandom_range(0, eff_size(grid_size[CFG_SIZE_Y], MAX_Y) - 1));
			r.z    = COORD_W'($urandom_range(0, eff_size(grid_size[CFG_SIZE_Z], MAX_Z) - 1));
		end else begin
			r.mode = ($urandom_range(0, 99) < 60) ? MODE_CLASSIFY : MODE_WRITE;
			r.x    = COORD_W'(box_x0 + int'($urandom_range(0, box_nx - 1)));
			r.y    = COORD_W'(box_y0 + int'($urandom_range(0, box_ny - 1)));
			r.z    = COORD_W'(box_z0 + int'($urandom_range(0, box_nz - 1)));
		end
		if (r.mode == MODE_CLASSIFY && !read_is_defined(r))
			r.mode = MODE_WRITE;
		return r;
	endfunction

	// one grid setting: fill a small box, let it drain, then random traffic
	task automatic run_grid(input logic [SIZE_W-1:0] nx, ny, nz, input int n_rand,
			input int occ_pct, input bit busy_sides);
		int sx, sy, sz;
		set_grid(nx, ny, nz);
		sx = eff_size(nx, MAX_X);
		sy = eff_size(ny, MAX_Y);
		sz = eff_size(nz, MAX_Z);
		box_nx = (sx < BOX_MAX) ? sx : BOX_MAX;
		box_ny = (sy < BOX_MAX) ? sy : BOX_MAX;
		box_nz = (sz < BOX_MAX) ? sz : BOX_MAX;
		box_x0 = $urandom_range(0, sx - box_nx);
		box_y0 = $urandom_range(0, sy - box_ny);
		box_z0 = $urandom_range(0, sz - box_nz);
		tx_idle  = busy_sides && ($urandom_range(0, 3) != 0);
		rx_style = busy_sides ? rx_style_t'($urandom_range(0, 2)) : RX_ALWAYS;
		for (int x = 0; x < box_nx; x++)
			for (int y = 0; y < box_ny; y++)
				for (int z = 0; z < box_nz; z++)
					send_voxel(vox(MODE_WRITE, box_x0 + x, box_y0 + y, box_z0 + z,
						$urandom_range(0, 99) < occ_pct));
		drain_results();
		repeat (n_rand)
			send_voxel(random_voxel(occ_pct));
	endtask

	task automatic test_reset_extremes();
		tx_idle  = 1'b0;
		rx_style = RX_PATTERN;
		send_voxel(vox(MODE_WRITE, 63, 63, 63, 1'b1));
		send_voxel(vox(MODE_CLASSIFY, 63, 63, 63, 1'b0));
		send_voxel(vox(MODE_WRITE, 0, 0, 0, 1'b0));
		send_voxel(vox(MODE_CLASSIFY, 0, 0, 0, 1'b1));
		send_voxel(vox(MODE_WRITE, 0, 63, 0, 1'b1));
		send_voxel(vox(MODE_CLASSIFY, 0, 63, 0, 1'b0));
		send_voxel(vox(MODE_WRITE, 31, 31, 0, 1'b1));
		send_voxel(vox(MODE_CLASSIFY, 31, 31, 0, 1'b0));
	endtask

	task automatic test_size_registers();
		// sizes above the maximum behave as the maximum
		set_grid(7'd127, 7'd127, 7'd127);
		send_voxel(vox(MODE_CLASSIFY, 63, 63, 63, 1'b0));
		send_voxel(vox(MODE_WRITE, 63, 0, 63, 1'b0));
		send_voxel(vox(MODE_CLASSIFY, 63, 0, 63, 1'b1));
		// zero size: everything out of range, write dropped
		set_grid(7'd0, 7'd0, 7'd0);
		send_voxel(vox(MODE_WRITE, 0, 0, 0, 1'b1));
		send_voxel(vox(MODE_CLASSIFY, 0, 0, 0, 1'b0));
		// single layer: ground is also top, so stored value is kept
		set_grid(7'd64, 7'd64, 7'd1);
		send_voxel(vox(MODE_CLASSIFY, 31, 31, 0, 1'b0));
		send_voxel(vox(MODE_CLASSIFY, 31, 31, 1, 1'b0));
		set_grid(7'd64, 7'd64, 7'd2);
		send_voxel(vox(MODE_CLASSIFY, 31, 31, 0, 1'b0));
		send_voxel(vox(MODE_WRITE, 31, 31, 1, 1'b1));
		send_voxel(vox(MODE_CLASSIFY, 31, 31, 1, 1'b0));
		// smallest legal grid, coordinates just past each edge
		set_grid(7'd3, 7'd3, 7'd2);
		send_voxel(vox(MODE_CLASSIFY, 3, 0, 0, 1'b0));
		send_voxel(vox(MODE_WRITE, 0, 3, 0, 1'b1));
		send_voxel(vox(MODE_WRITE, 0, 0, 2, 1'b1));
		send_voxel(vox(MODE_CLASSIFY, 63, 63, 63, 1'b0));
	endtask

	task automatic test_random_grids();
		run_grid(7'd3, 7'd3, 7'd2, 60, 90, 1'b1);
		run_grid(7'd3, 7'd3, 7'd3, 60, 95, 1'b1);
		run_grid(7'd64, 7'd64, 7'd64, 90, 95, 1'b1);
		run_grid(7'd127, 7'd127, 7'd127, 90, 92, 1'b0);
		run_grid(7'd5, 7'd5, 7'd5, 90, 97, 1'b1);
		run_grid(7'd6, 7'd4, 7'd7, 90, 93, 1'b1);
		run_grid(7'd2, 7'd1, 7'd1, 30, 50, 1'b1);
		repeat (2)
			run_grid(SIZE_W'($urandom_range(3, 12)), SIZE_W'($urandom_range(3, 12)),
				SIZE_W'($urandom_range(2, 12)), 90, 94, 1'b1);
	endtask

	// result side held off long enough for the block to stall its input
	task automatic test_backpressure();
		run_grid(7'd7, 7'd7, 7'd7, 0, 96, 1'b0);
		hold_req = 300;
		repeat (60)
			send_voxel(random_voxel(96));
		drain_results();
	endtask

	initial begin
		fail_count = 0;
		n_items    = 0;
		n_results  = 0;
		n_settings = 0;
		n_err      = 0;
		n_class    = '{0, 0, 0, 0};
		burst_left = 0;
		hold_req   = 0;
		tx_idle    = 1'b0;
		rx_style   = RX_ALWAYS;
		grid_size  = '{SIZE_RESET, SIZE_RESET, SIZE_RESET};
		arst_n          <= 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.mode     <= MODE_WRITE;
		req_ch.coord_x  <= '0;
		req_ch.coord_y  <= '0;
		req_ch.coord_z  <= '0;
		req_ch.occupied <= 1'b0;
		cfg_ch.valid    <= 1'b0;
		cfg_ch.index    <= CFG_SIZE_X;
		cfg_ch.data     <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_extremes();
		test_size_registers();
		test_random_grids();
		test_backpressure();

		drain_results();
		repeat (END_SETTLE) @(posedge clk);
		if (face_q.size() != 0)
			report_mismatch("results still pending at end", 0, face_q.size());
		$display("%0d items over %0d grid settings, %0d results checked (%0d out of range)",
			n_items, n_settings, n_results, n_err);
		$display("classes: empty %0d, solid %0d, vertical %0d, horizontal %0d",
			n_class[CLS_EMPTY], n_class[CLS_SOLID], n_class[CLS_VERTICAL],
			n_class[CLS_HORIZONTAL]);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* filelist.f */
src/vsfc_pkg.sv
src/vsfc_if.sv
src/vsfc_ram.sv
src/vsfc_ctrl.sv
src/vsfc_dp.sv
src/voxel_surface_face_classifier.sv
tb/voxel_surface_face_classifier_test.sv
